// File: hw/rtl/reloading_irq_counter_unit_macros.svh
// Assertion macros for the reloading interrupt counter unit.
// Included by the top level; has no dependencies of its own.
`ifndef RELOADING_IRQ_COUNTER_UNIT_MACROS_SVH
`define RELOADING_IRQ_COUNTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ric assertion failed");
`define RIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ric assertion failed");
`else
`define RIC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RIC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/ric_pkg.sv
// Package for the reloading interrupt counter unit: transaction types and codes.
// No dependencies.
package ric_pkg;

  localparam int unsigned CountWidth = 16;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [2:0] REG_NIB0 = 3'd0;
  localparam logic [2:0] REG_NIB1 = 3'd1;
  localparam logic [2:0] REG_NIB2 = 3'd2;
  localparam logic [2:0] REG_NIB3 = 3'd3;
  localparam logic [2:0] REG_CTRL = 3'd4;
  localparam logic [2:0] REG_ACK  = 3'd5;

  localparam int unsigned CTRL_REARM = 0;
  localparam int unsigned CTRL_EN    = 1;
  localparam int unsigned CTRL_MODE8 = 2;

  typedef struct packed {
    logic       kind;
    logic [2:0] reg_select;
    logic [7:0] write_data;
  } ric_in_t;

  typedef struct packed {
    logic                  irq_asserted;
    logic [CountWidth-1:0] count_now;
  } ric_out_t;

endpackage

// File: hw/rtl/ric_in_reg.sv
// Input register of the reloading interrupt counter unit.
// Depends on ric_pkg for the input transaction type.
module ric_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ric_pkg::ric_in_t in_data,
  input  logic             advance,
  output logic             stage_valid,
  output ric_pkg::ric_in_t stage_item
);

  logic             valid_r;
  logic             valid_nxt;
  ric_pkg::ric_in_t item_r;

  assign in_ready    = !valid_r || advance;
  assign valid_nxt   = (in_valid && in_ready) || (valid_r && !advance);
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

// File: hw/rtl/ric_core.sv
// Register file and counter of the reloading interrupt counter unit.
// Depends on ric_pkg for types, register codes and control bit positions.
module ric_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  ric_pkg::ric_in_t  item,
  output ric_pkg::ric_out_t result
);

  logic [ric_pkg::CountWidth-1:0] reload_r;
  logic [ric_pkg::CountWidth-1:0] reload_nxt;
  logic [2:0]                     ctrl_r;
  logic [2:0]                     ctrl_nxt;
  logic [ric_pkg::CountWidth-1:0] count_r;
  logic [ric_pkg::CountWidth-1:0] count_nxt;
  logic                           irq_r;
  logic                           irq_nxt;
  logic                           wrap;

  assign wrap = ctrl_r[ric_pkg::CTRL_MODE8] ? (&count_r[7:0]) : (&count_r);

  always_comb begin
    reload_nxt = reload_r;
    ctrl_nxt   = ctrl_r;
    count_nxt  = count_r;
    irq_nxt    = irq_r;
    if (step_en) begin
      if (item.kind == ric_pkg::KIND_TICK) begin
        if (ctrl_r[ric_pkg::CTRL_EN]) begin
          if (wrap) begin
            count_nxt = reload_r;
            irq_nxt   = 1'b1;
          end else begin
            count_nxt = count_r + 16'd1;
          end
        end
      end else begin
        case (item.reg_select)
          ric_pkg::REG_NIB0: reload_nxt[3:0]   = item.write_data[3:0];
          ric_pkg::REG_NIB1: reload_nxt[7:4]   = item.write_data[3:0];
          ric_pkg::REG_NIB2: reload_nxt[11:8]  = item.write_data[3:0];
          ric_pkg::REG_NIB3: reload_nxt[15:12] = item.write_data[3:0];
          ric_pkg::REG_CTRL: begin
            ctrl_nxt = item.write_data[2:0];
            if (item.write_data[ric_pkg::CTRL_EN]) begin
              count_nxt = reload_r;
            end
            irq_nxt = 1'b0;
          end
          ric_pkg::REG_ACK: begin
            ctrl_nxt[ric_pkg::CTRL_EN] = ctrl_r[ric_pkg::CTRL_REARM];
            irq_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign result.irq_asserted = irq_nxt;
  assign result.count_now    = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= '0;
      ctrl_r   <= '0;
      count_r  <= '0;
      irq_r    <= 1'b0;
    end else begin
      reload_r <= reload_nxt;
      ctrl_r   <= ctrl_nxt;
      count_r  <= count_nxt;
      irq_r    <= irq_nxt;
    end
  end

endmodule

// File: hw/rtl/reloading_irq_counter_unit.sv
// Top level of the reloading interrupt counter unit.
// Depends on ric_pkg, ric_in_reg, ric_core and reloading_irq_counter_unit_macros.svh.
//
// Each input transaction is either a register write (kind 0) or one CPU
// clock tick (kind 1). Registers 0 to 3 set the nibbles of the 16-bit reload
// value, register 4 sets the control bits and clears the interrupt, and
// register 5 acknowledges the interrupt. Every input transaction produces
// exactly one result transaction with the interrupt flag and the counter
// value after that transaction.
// A transaction accepted into the input register waits there until the output
// register can take a result, is then processed against the counter state, and
// its result is written to the output register at the same edge as the counter
// update. One transaction is accepted every cycle while the output is not
// stalled; the limit is the single counter update performed per cycle.
// Synchronous reset clears the reload value, control bits, counter and
// interrupt flag and empties both pipeline registers. When the receiver
// stalls, the result stays in the output register, the input register
// keeps one more transaction, and in_ready falls once both are full.
`include "reloading_irq_counter_unit_macros.svh"

module reloading_irq_counter_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ric_pkg::ric_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ric_pkg::ric_out_t out_data
);

  logic              advance;
  logic              stage_valid;
  ric_pkg::ric_in_t  stage_item;
  ric_pkg::ric_out_t core_result;
  logic              out_valid_r;
  logic              out_valid_nxt;
  ric_pkg::ric_out_t out_data_r;
  logic              ctrl_write;
  logic              ack_write;
  logic              tick_step;

  assign advance       = stage_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  ric_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  ric_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (stage_item),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ctrl_write = advance && (stage_item.kind == ric_pkg::KIND_WRITE) &&
                      (stage_item.reg_select == ric_pkg::REG_CTRL);
  assign ack_write  = advance && (stage_item.kind == ric_pkg::KIND_WRITE) &&
                      (stage_item.reg_select == ric_pkg::REG_ACK);
  assign tick_step  = advance && (stage_item.kind == ric_pkg::KIND_TICK);

  `RIC_ASSERT_NEXT(a_ctrl_clears_irq, clk, rst_n, ctrl_write, !out_data_r.irq_asserted)
  `RIC_ASSERT_NEXT(a_ack_clears_irq, clk, rst_n, ack_write, !out_data_r.irq_asserted)
  `RIC_ASSERT_SAME(a_irq_from_tick, clk, rst_n, $rose(out_data_r.irq_asserted), $past(tick_step))
  `RIC_ASSERT_NEXT(a_stage_holds, clk, rst_n, stage_valid && !advance, stage_valid)

endmodule
